>>> rtl/core/rnra_pkg.sv
// shared constants and types of the ring neighbour resource arbiter
package rnra_pkg;

    // default ring size
    localparam int unsigned ARB_COUNT = 1024;

    // field and bus widths
    localparam int ID_W      = 10;
    localparam int CMP_W     = 17;
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 1;
    localparam int RES_W     = 22;
    localparam int M_TDATA_W = 24;

    // per-client status as held in the status memory
    typedef enum logic [1:0] {
        ST_THINKING = 2'd0,
        ST_HUNGRY   = 2'd1,
        ST_EATING   = 2'd2
    } t_status;

    // request kind
    typedef enum logic {
        OP_TAKE = 1'b0,
        OP_PUT  = 1'b1
    } t_op;

    // one result, last field in the lowest bits
    typedef struct packed {
        logic [ID_W-1:0] b_id;
        logic            b_valid;
        logic [ID_W-1:0] a_id;
        logic            a_valid;
    } t_result;

endpackage

>>> rtl/core/ring_neighbour_resource_arbiter.sv
// top level of the ring neighbour resource arbiter (dining philosophers)
//
// COUNT clients sit in a ring and each one shares a resource with the client on either side.
// a take request marks the client hungry and grants it when neither neighbour is eating; a put
// request marks it thinking and then tests the left and the right neighbour, granting each one
// that is hungry with no eating neighbour. every request gives exactly one result carrying up
// to two grants; a client id not below COUNT gives an empty result and changes nothing. all
// status lives in one COUNT-entry memory with a single read port, and the reads of that port
// set the pace: a take makes two reads, a put four reads and an out-of-range id none. a new
// request is taken once the previous one has written back and its result has entered the
// output register, where it may still wait. after reset the memory is swept to thinking,
// one entry a cycle, so no request is taken until the sweep has reached the last entry.
module ring_neighbour_resource_arbiter #(
    parameter int unsigned COUNT = rnra_pkg::ARB_COUNT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request side
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [rnra_pkg::S_TDATA_W-1:0] i_s_axis_tdata,   // client_id[9:0], zero pad
    input  logic [rnra_pkg::S_TUSER_W-1:0] i_s_axis_tuser,   // op[0]
    // result side
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // grant_a_valid[0], grant_a_id[10:1], grant_b_valid[11], grant_b_id[21:12], zero pad
    output logic [rnra_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);

    import rnra_pkg::*;

    localparam int IDX_W = (COUNT > 1) ? $clog2(COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(COUNT - 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_RUN   = 4'b0100,
        S_HOLD  = 4'b1000
    } t_state;

    // ring neighbours with wrap-around
    function automatic logic [IDX_W-1:0] left_of(input logic [IDX_W-1:0] id);
        return (id == '0) ? LAST : id - IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] right_of(input logic [IDX_W-1:0] id);
        return (id == LAST) ? '0 : id + IDX_W'(1);
    endfunction

    // low id bits of a ring index
    function automatic logic [ID_W-1:0] to_id(input logic [IDX_W-1:0] idx);
        logic [CMP_W-1:0] w;
        w = CMP_W'(idx);
        return w[ID_W-1:0];
    endfunction

    // control and payload registers
    t_state          r_state, n_state;
    logic [1:0]      r_step, n_step;
    t_op             r_op, n_op;
    logic            r_bad, n_bad;
    logic [IDX_W-1:0] r_id, n_id;
    logic [IDX_W-1:0] r_l, n_l;
    logic [1:0]      r_s_l, n_s_l;      // left status, later right status
    logic            r_ga, n_ga;        // left neighbour granted on put
    logic [IDX_W-1:0] r_clr, n_clr;
    t_result         r_res, n_res;
    logic            r_out_valid, n_out_valid;
    t_result         r_out, n_out;

    // memory port
    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [1:0]       ram_wdata, ram_rdata;

    // request decode
    logic [ID_W-1:0]  in_cid;
    logic [CMP_W-1:0] in_wide;
    logic             in_ok;
    logic [IDX_W-1:0] in_idx;
    t_op              in_op;
    logic             accept;
    logic             out_free;

    // neighbours of the request in flight
    logic [IDX_W-1:0] nb_r, nb_ll, nb_rr;
    logic             r_eq_l;

    logic             fin;
    logic             grant;
    t_result          res;

    assign in_cid  = i_s_axis_tdata[ID_W-1:0];
    assign in_wide = CMP_W'(in_cid);
    assign in_ok   = in_wide < CMP_W'(COUNT);
    assign in_idx  = in_wide[IDX_W-1:0];
    assign in_op   = t_op'(i_s_axis_tuser[0]);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    assign nb_r   = right_of(r_id);
    assign nb_ll  = left_of(r_l);
    assign nb_rr  = right_of(nb_r);
    // two-client ring: left and right neighbour are one entry
    assign r_eq_l = (nb_r == r_l);

    rnra_ram #(
        .WIDTH (2),
        .DEPTH (COUNT)
    ) u_status_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_op        = r_op;
        n_bad       = r_bad;
        n_id        = r_id;
        n_l         = r_l;
        n_s_l       = r_s_l;
        n_ga        = r_ga;
        n_clr       = r_clr;
        n_res       = r_res;
        ram_we      = 1'b0;
        ram_waddr   = r_id;
        ram_wdata   = ST_THINKING;
        ram_re      = 1'b0;
        ram_raddr   = r_l;
        fin         = 1'b0;
        grant       = 1'b0;
        res         = '0;

        unique case (r_state)
            S_CLEAR: begin
                // sweep the status memory to thinking
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = ST_THINKING;
                n_clr     = r_clr + IDX_W'(1);
                if (r_clr == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_op    = in_op;
                    n_id    = in_idx;
                    n_l     = left_of(in_idx);
                    n_bad   = !in_ok;
                    n_step  = 2'd0;
                    n_state = S_RUN;
                    // left neighbour is read first for both kinds
                    ram_re    = in_ok;
                    ram_raddr = left_of(in_idx);
                    // a put leaves the client thinking before any neighbour test
                    if (in_ok && in_op == OP_PUT) begin
                        ram_we    = 1'b1;
                        ram_waddr = in_idx;
                        ram_wdata = ST_THINKING;
                    end
                end
            end
            S_RUN: begin
                n_step = r_step + 2'd1;
                if (r_bad) begin
                    // out-of-range client: empty result
                    fin = 1'b1;
                end else if (r_op == OP_TAKE) begin
                    unique case (r_step)
                        2'd0: begin
                            ram_re    = 1'b1;
                            ram_raddr = nb_r;
                            n_s_l     = ram_rdata;
                        end
                        2'd1: begin
                            fin       = 1'b1;
                            grant     = (r_s_l != ST_EATING) && (ram_rdata != ST_EATING);
                            ram_we    = 1'b1;
                            ram_waddr = r_id;
                            ram_wdata = grant ? ST_EATING : ST_HUNGRY;
                            res.a_valid = grant;
                            res.a_id    = grant ? to_id(r_id) : '0;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end else begin
                    unique case (r_step)
                        2'd0: begin
                            // status of left neighbour arrives, read its own left
                            ram_re    = 1'b1;
                            ram_raddr = nb_ll;
                            n_s_l     = ram_rdata;
                        end
                        2'd1: begin
                            // left test: its right side is the releasing client, thinking
                            grant     = (r_s_l == ST_HUNGRY) && (ram_rdata != ST_EATING);
                            n_ga      = grant;
                            ram_we    = grant;
                            ram_waddr = r_l;
                            ram_wdata = ST_EATING;
                            ram_re    = 1'b1;
                            ram_raddr = nb_r;
                        end
                        2'd2: begin
                            // right status, forwarded when it is the entry just granted
                            ram_re    = 1'b1;
                            ram_raddr = nb_rr;
                            n_s_l     = (r_eq_l && r_ga) ? ST_EATING : ram_rdata;
                        end
                        default: begin
                            // right test: its left side is the releasing client, thinking
                            fin       = 1'b1;
                            grant     = (r_s_l == ST_HUNGRY) && (ram_rdata != ST_EATING);
                            ram_we    = grant;
                            ram_waddr = nb_r;
                            ram_wdata = ST_EATING;
                            res.a_valid = r_ga;
                            res.a_id    = r_ga ? to_id(r_l) : '0;
                            res.b_valid = grant;
                            res.b_id    = grant ? to_id(nb_r) : '0;
                        end
                    endcase
                end
                if (fin) begin
                    n_res   = res;
                    n_state = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register, loaded straight from the last step or from the held result
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_state == S_RUN && fin && out_free) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (r_state == S_HOLD && out_free) begin
            n_out_valid = 1'b1;
            n_out       = r_res;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_step      <= 2'd0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_bad <= n_bad;
        r_id  <= n_id;
        r_l   <= n_l;
        r_s_l <= n_s_l;
        r_ga  <= n_ga;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_TDATA_W'(r_out);

    // an accepted request always enters the run state
    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_RUN))
        else $error("accepted request did not start");

    // a take never produces a second grant
    a_take_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && fin && r_op == OP_TAKE) |-> !res.b_valid)
        else $error("take produced a second grant");

    // same-entry read and write in one cycle only where forwarding covers it
    a_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re && ram_waddr == ram_raddr) |->
            (r_state == S_RUN && r_op == OP_PUT && r_step == 2'd1 && r_eq_l))
        else $error("unforwarded read-during-write on status memory");

endmodule

>>> rtl/core/rnra_ram.sv
// generic simple dual-port ram with registered read
module rnra_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
